/* src/sorted_sparse_triplet_table_defines.svh */
// Assertion macros shared by the sorted sparse triplet table RTL.
// Used by files that carry concurrent checks; relies on clk and rst_n in scope.
`ifndef SORTED_SPARSE_TRIPLET_TABLE_DEFINES_SVH
`define SORTED_SPARSE_TRIPLET_TABLE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SSTT_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SSTT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sstt_pkg.sv */
// Shared types and codes for the sorted sparse triplet table.
// No dependencies; imported by sstt_cell, sorted_sparse_triplet_table and the bench.
package sstt_pkg;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_NUM_ROWS = 1'b0,
    CFG_NUM_COLS = 1'b1
  } cfg_idx_t;

  // Control part of the search token walking the cell chain.
  typedef struct packed {
    logic active;  // token present in this stage
    cmd_t cmd;
    logic placed;  // match or insertion point already found
    logic hit;     // matching entry found
    logic drop;    // insert refused, table full
  } tok_ctl_t;

endpackage

/* src/sstt_cell.sv */
// One table slot of the sorted sparse triplet table chain.
// Depends on sstt_pkg for the token control struct.
module sstt_cell import sstt_pkg::*; #(
  parameter int KEY_W    = 16,
  parameter int VAL_W    = 32,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count,
  input  logic             full,
  input  tok_ctl_t         tok_ctl_in,
  input  logic [KEY_W-1:0] tok_key_in,
  input  logic [VAL_W-1:0] tok_val_in,
  output tok_ctl_t         tok_ctl_out,
  output logic [KEY_W-1:0] tok_key_out,
  output logic [VAL_W-1:0] tok_val_out
);

  logic [KEY_W-1:0] ent_key_r, ent_key_nxt;
  logic [VAL_W-1:0] ent_val_r, ent_val_nxt;
  tok_ctl_t         ctl_r, ctl_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             slot_valid;

  assign slot_valid = CNT_W'(CELL_IDX) < count;

  always_comb begin
    ctl_nxt     = tok_ctl_in;
    key_nxt     = tok_key_in;
    val_nxt     = tok_val_in;
    ent_key_nxt = ent_key_r;
    ent_val_nxt = ent_val_r;
    if (tok_ctl_in.active) begin
      if (!tok_ctl_in.placed) begin
        if (slot_valid && ent_key_r == tok_key_in) begin
          ctl_nxt.placed = 1'b1;
          ctl_nxt.hit    = 1'b1;
          if (tok_ctl_in.cmd == CMD_WRITE) begin
            ent_val_nxt = tok_val_in;
          end else begin
            val_nxt = ent_val_r;
          end
        end else if (!slot_valid || ent_key_r > tok_key_in) begin
          ctl_nxt.placed = 1'b1;
          if (tok_ctl_in.cmd == CMD_WRITE) begin
            if (full) begin
              ctl_nxt.drop = 1'b1;
            end else begin
              // take the new entry, pass the old one on
              ent_key_nxt = tok_key_in;
              ent_val_nxt = tok_val_in;
              key_nxt     = ent_key_r;
              val_nxt     = ent_val_r;
            end
          end
        end
      end else if (tok_ctl_in.cmd == CMD_WRITE && !tok_ctl_in.hit && !tok_ctl_in.drop) begin
        // ripple the displaced entry up one slot
        ent_key_nxt = tok_key_in;
        ent_val_nxt = tok_val_in;
        key_nxt     = ent_key_r;
        val_nxt     = ent_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_key_r <= ent_key_nxt;
    ent_val_r <= ent_val_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
  end

  assign tok_ctl_out = ctl_r;
  assign tok_key_out = key_r;
  assign tok_val_out = val_r;

endmodule

/* src/sorted_sparse_triplet_table.sv */
// Channel | Direction | Contents (lowest bits first)
// in_*    | slave     | tdata: command, row_index, col_index, write_value
// out_*   | master    | tdata: status, read_value, entry_total
// cfg_*   | write     | cfg_addr 0 num_rows, 1 num_cols; cfg_wdata value
//
// An in-range command is accepted in idle; a search token then walks the chain
// of TABLE_DEPTH slot cells, one cell per cycle, the result is captured, and it
// moves to the output register once that is free, before the next acceptance.
// An out-of-range command skips the walk. Reset empties the table and sets
// both limits to 2**INDEX_BITS. A stalled output holds in its register while
// the next command is accepted and processed.
// Top level; depends on sstt_pkg, sstt_cell and the defines header.
`include "sorted_sparse_triplet_table_defines.svh"

module sorted_sparse_triplet_table import sstt_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int INDEX_BITS  = 8,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // command, row_index, col_index, write_value; zero padded to bytes
  input  logic [((1 + 2 * INDEX_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status, read_value, entry_total; zero padded to bytes
  output logic [((2 + VALUE_BITS + $clog2(TABLE_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [INDEX_BITS:0]   cfg_wdata
);

  localparam int KEY_W = 2 * INDEX_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_W = ((2 + VALUE_BITS + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [INDEX_BITS:0]   num_rows_r, num_cols_r;
  logic [1:0]            res_status_r, out_status_r;
  logic [VALUE_BITS-1:0] res_val_r, out_val_r;
  logic [CNT_W-1:0]      res_total_r, out_total_r;
  logic                  out_tvalid_r;

  logic                  in_acc;
  logic                  out_load;
  cmd_t                  in_cmd;
  logic [INDEX_BITS-1:0] in_row, in_col;
  logic [VALUE_BITS-1:0] in_val;
  logic                  range_ok, full;

  tok_ctl_t              tok_ctl [0:TABLE_DEPTH];
  logic [KEY_W-1:0]      tok_key [0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] tok_val [0:TABLE_DEPTH];
  logic [TABLE_DEPTH:1]  tok_act;
  tok_ctl_t              inj_ctl;
  tok_ctl_t              last_ctl;

  assign in_cmd = cmd_t'(in_tdata[0]);
  assign in_row = in_tdata[INDEX_BITS:1];
  assign in_col = in_tdata[KEY_W:INDEX_BITS+1];
  assign in_val = in_tdata[KEY_W+VALUE_BITS:KEY_W+1];

  assign in_tready = state_r == ST_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign range_ok  = ({1'b0, in_row} < num_rows_r) && ({1'b0, in_col} < num_cols_r);
  assign full      = count_r == CNT_W'(TABLE_DEPTH);
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    inj_ctl        = '0;
    inj_ctl.active = in_acc && range_ok;
    inj_ctl.cmd    = in_cmd;
  end

  assign tok_ctl[0] = inj_ctl;
  assign tok_key[0] = {in_row, in_col};
  assign tok_val[0] = in_val;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sstt_cell #(
      .KEY_W    (KEY_W),
      .VAL_W    (VALUE_BITS),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .count       (count_r),
      .full        (full),
      .tok_ctl_in  (tok_ctl[g]),
      .tok_key_in  (tok_key[g]),
      .tok_val_in  (tok_val[g]),
      .tok_ctl_out (tok_ctl[g+1]),
      .tok_key_out (tok_key[g+1]),
      .tok_val_out (tok_val[g+1])
    );
    assign tok_act[g+1] = tok_ctl[g+1].active;
  end

  assign last_ctl = tok_ctl[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      num_rows_r   <= (INDEX_BITS + 1)'(1 << INDEX_BITS);
      num_cols_r   <= (INDEX_BITS + 1)'(1 << INDEX_BITS);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_NUM_ROWS: num_rows_r <= cfg_wdata;
          CFG_NUM_COLS: num_cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (range_ok) begin
              state_r <= ST_WALK;
            end else begin
              res_status_r <= STAT_RANGE;
              res_val_r    <= '0;
              res_total_r  <= count_r;
              state_r      <= ST_DONE;
            end
          end
        end
        ST_WALK: begin
          if (last_ctl.active) begin
            if (last_ctl.cmd == CMD_READ) begin
              res_status_r <= STAT_OK;
              res_val_r    <= last_ctl.hit ? tok_val[TABLE_DEPTH] : '0;
              res_total_r  <= count_r;
            end else if (!last_ctl.hit && (last_ctl.drop || !last_ctl.placed)) begin
              res_status_r <= STAT_FULL;
              res_val_r    <= '0;
              res_total_r  <= count_r;
            end else if (!last_ctl.hit) begin
              res_status_r <= STAT_OK;
              res_val_r    <= '0;
              count_r      <= count_r + CNT_W'(1);
              res_total_r  <= count_r + CNT_W'(1);
            end else begin
              res_status_r <= STAT_OK;
              res_val_r    <= '0;
              res_total_r  <= count_r;
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand off once the output register is free
          if (out_load) begin
            out_status_r <= res_status_r;
            out_val_r    <= res_val_r;
            out_total_r  <= res_total_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_total_r, out_val_r, out_status_r});

  `SSTT_ASSERT_HOLD(a_count_cap, count_r <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `SSTT_ASSERT_HOLD(a_one_token, $countones(tok_act) <= 1, "more than one token in chain")
  `SSTT_ASSERT_NEXT(a_count_step, 1'b1,
    count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1),
    "entry count jumped")
  `SSTT_ASSERT_IMPL(a_full_total, out_tvalid && out_status_r == STAT_FULL,
    out_total_r == CNT_W'(TABLE_DEPTH), "full status with room left")
  `SSTT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, state_r != ST_IDLE,
    "idle right after accepting a command")

endmodule

/* dv/sorted_sparse_triplet_table_tb.sv */
// Self-checking bench for sorted_sparse_triplet_table: reads, writes and range
// errors under random stream stalls, scored against an in-bench table model.
// Depends on sstt_pkg and the RTL top level only.
module sorted_sparse_triplet_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sstt_pkg::*;

  localparam int DEPTH      = 64;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_SPAN  = 600;
  localparam int SETTLE     = DEPTH + 6;

  typedef struct {
    status_t     status;
    logic [31:0] rd;
    logic [6:0]  total;
  } answer_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_t    reg_idx;
    logic [8:0]  reg_val;
    cmd_t        cmd;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    bit          typed;
    answer_t     want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // command, row_index, col_index, write_value (lowest bits first)
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // status, read_value, entry_total (lowest bits first)
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  // table model
  logic [7:0]  slot_row [DEPTH];
  logic [7:0]  slot_col [DEPTH];
  logic [31:0] slot_val [DEPTH];
  int          slot_count = 0;
  int          lim_rows = 256;
  int          lim_cols = 256;

  answer_t     pending_answers[$];
  step_t       plan[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 73;
  int          stall_asks = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          rand_sent = 0;

  sorted_sparse_triplet_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random back-pressure plus a long hold on request.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_asks) begin
      stall_seen <= stall_asks;
      stall_left <= HOLD_SPAN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.rd     = out_tdata[33:2];
      got.total  = out_tdata[40:34];
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none, actual %h", $time, out_tdata);
      end else begin
        exp_a = pending_answers.pop_front();
        if (got.status != exp_a.status) begin
          mismatch_count++;
          $display("%0t status: expected %0d actual %0d", $time, exp_a.status, got.status);
        end
        if (got.rd != exp_a.rd) begin
          mismatch_count++;
          $display("%0t read_value: expected %h actual %h", $time, exp_a.rd, got.rd);
        end
        if (got.total != exp_a.total) begin
          mismatch_count++;
          $display("%0t entry_total: expected %0d actual %0d", $time, exp_a.total,
                   got.total);
        end
      end
    end
  end

  // Check the limits, search the sorted table, then read, update, insert with shift, or refuse.
  function automatic answer_t predict_answer(cmd_t cmd, logic [7:0] r, logic [7:0] c,
                                             logic [31:0] v);
    answer_t a;
    int      k;
    bit      hit;
    a.status = STAT_OK;
    a.rd     = '0;
    if (int'(r) >= lim_rows || int'(c) >= lim_cols) begin
      a.status = STAT_RANGE;
    end else begin
      k = 0;
      while (k < slot_count && slot_row[k] < r) k++;
      while (k < slot_count && slot_row[k] == r && slot_col[k] < c) k++;
      hit = (k < slot_count) && slot_row[k] == r && slot_col[k] == c;
      if (cmd == CMD_READ) begin
        if (hit) a.rd = slot_val[k];
      end else if (hit) begin
        slot_val[k] = v;
      end else if (slot_count >= DEPTH) begin
        a.status = STAT_FULL;
      end else begin
        for (int m = slot_count; m > k; m--) begin
          slot_row[m] = slot_row[m - 1];
          slot_col[m] = slot_col[m - 1];
          slot_val[m] = slot_val[m - 1];
        end
        slot_row[k] = r;
        slot_col[k] = c;
        slot_val[k] = v;
        slot_count++;
      end
    end
    a.total = slot_count[6:0];
    return a;
  endfunction

  function automatic void plan_cmd(cmd_t c, logic [7:0] r, logic [7:0] col, logic [31:0] v,
                                   bit typed, status_t s, logic [31:0] rd, logic [6:0] total);
    step_t st;
    st.is_cfg      = 1'b0;
    st.reg_idx     = CFG_NUM_ROWS;
    st.reg_val     = '0;
    st.cmd         = c;
    st.row         = r;
    st.col         = col;
    st.value       = v;
    st.typed       = typed;
    st.want.status = s;
    st.want.rd     = rd;
    st.want.total  = total;
    plan.push_back(st);
  endfunction

  function automatic void plan_cfg(cfg_idx_t idx, logic [8:0] val);
    step_t st;
    st.is_cfg      = 1'b1;
    st.reg_idx     = idx;
    st.reg_val     = val;
    st.cmd         = CMD_READ;
    st.row         = '0;
    st.col         = '0;
    st.value       = '0;
    st.typed       = 1'b0;
    st.want.status = STAT_OK;
    st.want.rd     = '0;
    st.want.total  = '0;
    plan.push_back(st);
  endfunction

  // Drop valid and wait until every expected result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_NUM_ROWS) lim_rows = int'(val);
    else lim_cols = int'(val);
  endtask

  // Offer one command; entered and left at a rising-edge time step.
  task automatic send_cmd(cmd_t c, logic [7:0] r, logic [7:0] col, logic [31:0] v,
                          bit typed, answer_t want);
    answer_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, v, col, r, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_answer(c, r, col, v);
    pending_answers.push_back(typed ? want : pred);
  endtask

  task automatic run_phase(int rows, int cols, int rspan, int cspan, int count, bit pause_mid,
                           bit hold_out);
    cmd_t        c;
    logic [7:0]  r;
    logic [7:0]  col;
    logic [31:0] v;
    answer_t     none;
    none = '{STAT_OK, '0, '0};
    write_reg(CFG_NUM_ROWS, rows[8:0]);
    write_reg(CFG_NUM_COLS, cols[8:0]);
    // long output hold while commands keep coming
    if (hold_out) stall_asks <= stall_asks + 1;
    for (int i = 0; i < count; i++) begin
      if (rand_sent < 500) begin
        send_idle_pct <= 30;
        recv_idle_pct <= 73;
      end else if (rand_sent < 1000) begin
        send_idle_pct <= 73;
        recv_idle_pct <= 30;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (pause_mid && i == count / 2) drain();
      c = ($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_READ;
      // mostly a small hot region so entries get hit and the table fills
      if ($urandom_range(0, 99) < 15) begin
        r   = 8'($urandom_range(0, 255));
        col = 8'($urandom_range(0, 255));
      end else begin
        r   = 8'($urandom_range(0, rspan - 1));
        col = 8'($urandom_range(0, cspan - 1));
      end
      case ($urandom_range(0, 9))
        0:       v = 32'h0000_0000;
        1:       v = 32'h8000_0000;
        2:       v = 32'h7FFF_FFFF;
        3:       v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      send_cmd(c, r, col, v, 1'b0, none);
      rand_sent++;
    end
  endtask

  initial begin
    answer_t want;
    // empty table, extremes of index and value, ordered inserts
    plan_cmd(CMD_READ,  8'd0,   8'd0,   32'h1234_5678, 1'b1, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd255, 8'd255, 32'h0,         1'b1, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_WRITE, 8'd255, 8'd255, 32'h7FFF_FFFF, 1'b1, STAT_OK, 32'h0, 7'd1);
    plan_cmd(CMD_WRITE, 8'd0,   8'd0,   32'h8000_0000, 1'b1, STAT_OK, 32'h0, 7'd2);
    plan_cmd(CMD_READ,  8'd0,   8'd0,   32'h0, 1'b1, STAT_OK, 32'h8000_0000, 7'd2);
    plan_cmd(CMD_READ,  8'd255, 8'd255, 32'h0, 1'b1, STAT_OK, 32'h7FFF_FFFF, 7'd2);
    plan_cmd(CMD_WRITE, 8'd0,   8'd255, 32'hFFFF_FFFF, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_WRITE, 8'd255, 8'd0,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd255, 8'd0,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_WRITE, 8'd0,   8'd0,   32'h0000_0005, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd0,   8'd0,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_WRITE, 8'd128, 8'd128, 32'hAAAA_AAAA, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_WRITE, 8'd128, 8'd127, 32'h5555_5555, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd128, 8'd127, 32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd1,   8'd1,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd127, 8'd200, 32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    // index limits
    plan_cfg(CFG_NUM_ROWS, 9'd128);
    plan_cmd(CMD_WRITE, 8'd128, 8'd0,   32'hDEAD_BEEF, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd200, 8'd5,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cfg(CFG_NUM_COLS, 9'd1);
    plan_cmd(CMD_WRITE, 8'd3,   8'd1,   32'h0000_0001, 1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cmd(CMD_READ,  8'd0,   8'd0,   32'h0,         1'b0, STAT_OK, 32'h0, 7'd0);
    plan_cfg(CFG_NUM_ROWS, 9'd256);
    plan_cfg(CFG_NUM_COLS, 9'd256);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        want = plan[i].want;
        send_cmd(plan[i].cmd, plan[i].row, plan[i].col, plan[i].value, plan[i].typed, want);
      end
    end

    run_phase(1,   1,   2,  2,  150, 1'b0, 1'b0);
    run_phase(4,   5,   6,  6,  250, 1'b0, 1'b0);
    run_phase(256, 1,   12, 2,  250, 1'b0, 1'b0);
    run_phase(256, 256, 12, 12, 350, 1'b0, 1'b1);
    run_phase(37,  200, 40, 3,  250, 1'b1, 1'b0);
    run_phase(256, 256, 10, 10, 250, 1'b0, 1'b0);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
